>>> rtl/core/text_terminal_char_writer_unit_macros.svh
// Assertion macros shared by the text terminal character writer RTL.
`ifndef TEXT_TERMINAL_CHAR_WRITER_UNIT_MACROS_SVH
`define TEXT_TERMINAL_CHAR_WRITER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define TTCW_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ttcw assertion failed");
`define TTCW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttcw assertion failed");
`else
`define TTCW_ASSERT(lbl, cond)
`define TTCW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/ttcw_pkg.sv
// Types and constants of the text terminal character writer.
package ttcw_pkg;

  typedef logic [15:0] cell_t;
  typedef logic [7:0]  char_t;

  localparam char_t CH_NEWLINE   = 8'h0A;
  localparam char_t CH_TAB       = 8'h09;
  localparam char_t CH_BACKSPACE = 8'h08;
  localparam char_t CH_SPACE     = 8'h20;

  localparam char_t DEFAULT_ATTR = 8'h07;
  localparam cell_t BLANK_CELL   = {DEFAULT_ATTR, CH_SPACE};
  localparam cell_t NEWLINE_CELL = {8'h00, CH_NEWLINE};

  localparam int unsigned TAB_STEP = 8;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Register select is paddr[2]: register index times four.
  localparam logic REG_TEXT_ATTR = 1'b0;

endpackage

>>> rtl/core/text_terminal_char_writer_unit.sv
// Text terminal character writer: cell store, cursor and scroll sequencer.
//
//  port group | role            | transfer
//  -----------+-----------------+------------------------------------------
//  in_*       | item in         | tvalid & tready; tuser mode, tdata char/cell
//  out_*      | item out        | tvalid & tready; cursor and read data
//  cfg_*      | register access | APB write when psel & penable & pwrite
//
// Plain characters, tab and newline step through execute, post and finish;
// in-range reads step through execute, read wait and finish on the
// single-port-per-direction cell memory; a read beyond the store skips the wait.
// Backspace at column 0 searches the row above, a read and a check step per
// cell. A scroll copies each cell up one row, one copy per cycle, then blanks
// the bottom row. After reset a clearing pass blanks all cells before any item.
// A result that waits at the output holds the sequencer in its final step.
module text_terminal_char_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], cell_index[18:8], zero[23:19]
  input  logic        in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cursor_row[4:0], cursor_col[11:5],
                                  // read_data[27:12], zero[31:28]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NCELLS = ROWS * COLUMNS;
  localparam int AW     = $clog2(NCELLS);
  localparam int CW     = $clog2(NCELLS + 1);
  localparam int RW     = $clog2(ROWS + 1);
  localparam int CLW    = $clog2(COLUMNS + 1);
  localparam logic [CLW:0] TAB_LOW = (CLW + 1)'(ttcw_pkg::TAB_STEP - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_RD_WAIT, S_BS_RD, S_BS_CHK,
    S_POST, S_SC_COPY, S_SC_BLANK, S_FINISH
  } state_t;

  state_t                 state_r;
  logic [RW-1:0]          row_r;
  logic [CLW-1:0]         col_r;
  logic                   use_def_r;
  logic [7:0]             attr_r;
  logic [CW-1:0]          cnt_r;
  logic                   pend_v_r;
  logic [AW-1:0]          pend_addr_r;
  logic                   mode_r;
  ttcw_pkg::char_t        ch_r;
  logic [10:0]            cell_r;
  ttcw_pkg::cell_t        rdata_r;
  logic                   out_tvalid_r;
  logic [31:0]            out_tdata_r;

  ttcw_pkg::cell_t        mem [NCELLS];
  ttcw_pkg::cell_t        mem_q;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  ttcw_pkg::cell_t        wr_data;

  logic [AW-1:0]          cur_idx;
  logic [AW-1:0]          bs_addr;
  logic [CLW:0]           tab_sum;
  logic [CLW-1:0]         tab_col;
  logic                   cell_ok;
  logic                   col_wrap;
  logic [RW-1:0]          row_w;
  logic [7:0]             char_attr;
  logic                   out_load;
  logic                   cfg_wr;

  assign cur_idx   = AW'(row_r * COLUMNS) + AW'(col_r);
  assign bs_addr   = AW'((row_r - RW'(1)) * COLUMNS) + AW'(cnt_r);
  assign tab_sum   = ({1'b0, col_r} | TAB_LOW) + (CLW + 1)'(1);
  assign tab_col   = (tab_sum > (CLW + 1)'(COLUMNS)) ? CLW'(COLUMNS) : tab_sum[CLW-1:0];
  assign cell_ok   = {21'b0, cell_r} < 32'(NCELLS);
  assign col_wrap  = col_r >= CLW'(COLUMNS);
  assign row_w     = row_r + RW'(col_wrap);
  assign char_attr = use_def_r ? ttcw_pkg::DEFAULT_ATTR : attr_r;
  assign out_load  = (state_r == S_FINISH) && (!out_tvalid_r || out_tready);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == ttcw_pkg::REG_TEXT_ATTR) ? {24'b0, attr_r} : 32'b0;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = cur_idx;
    wr_data = ttcw_pkg::BLANK_CELL;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[AW-1:0];
      end
      S_EXEC: begin
        if (mode_r == ttcw_pkg::MODE_READ) begin
          rd_en   = cell_ok;
          rd_addr = AW'(cell_r);
        end else begin
          priority if (ch_r == ttcw_pkg::CH_NEWLINE) begin
            wr_en   = 1'b1;
            wr_data = ttcw_pkg::NEWLINE_CELL;
          end else if (ch_r == ttcw_pkg::CH_TAB) begin
            wr_en = 1'b0;
          end else if (ch_r == ttcw_pkg::CH_BACKSPACE) begin
            wr_en   = (col_r != '0);
            wr_addr = cur_idx - AW'(1);
          end else begin
            wr_en   = 1'b1;
            wr_data = {char_attr, ch_r};
          end
        end
      end
      S_BS_RD: begin
        rd_en   = 1'b1;
        rd_addr = bs_addr;
      end
      S_BS_CHK: begin
        wr_en   = (mem_q[7:0] == ttcw_pkg::CH_NEWLINE) || (cnt_r == CW'(COLUMNS - 1));
        wr_addr = bs_addr;
      end
      S_SC_COPY: begin
        rd_en   = cnt_r < CW'(NCELLS);
        wr_en   = pend_v_r;
        wr_addr = pend_addr_r;
        wr_data = mem_q;
      end
      S_SC_BLANK: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[AW-1:0];
      end
      S_IDLE, S_RD_WAIT, S_POST, S_FINISH: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      row_r        <= '0;
      col_r        <= '0;
      use_def_r    <= 1'b1;
      attr_r       <= ttcw_pkg::DEFAULT_ATTR;
      cnt_r        <= '0;
      pend_v_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_paddr[2] == ttcw_pkg::REG_TEXT_ATTR)) begin
        attr_r    <= cfg_pwdata[7:0];
        use_def_r <= 1'b0;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {4'b0, rdata_r, 7'(col_r), 5'(row_r)};
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (cnt_r == CW'(NCELLS - 1)) begin
            state_r <= S_IDLE;
          end
          cnt_r <= cnt_r + CW'(1);
        end
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r  <= in_tuser;
            ch_r    <= in_tdata[7:0];
            cell_r  <= in_tdata[18:8];
            rdata_r <= '0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (mode_r == ttcw_pkg::MODE_READ) begin
            state_r <= cell_ok ? S_RD_WAIT : S_FINISH;
          end else begin
            state_r <= S_POST;
            priority if (ch_r == ttcw_pkg::CH_NEWLINE) begin
              use_def_r <= 1'b1;
              col_r     <= '0;
              row_r     <= row_r + RW'(1);
            end else if (ch_r == ttcw_pkg::CH_TAB) begin
              col_r <= tab_col;
            end else if (ch_r == ttcw_pkg::CH_BACKSPACE) begin
              if (col_r != '0) begin
                col_r <= col_r - CLW'(1);
              end else if (row_r != '0) begin
                cnt_r   <= '0;
                state_r <= S_BS_RD;
              end
            end else begin
              col_r <= col_r + CLW'(1);
            end
          end
        end
        S_RD_WAIT: begin
          rdata_r <= mem_q;
          state_r <= S_FINISH;
        end
        S_BS_RD: begin
          state_r <= S_BS_CHK;
        end
        S_BS_CHK: begin
          if (wr_en) begin
            row_r   <= row_r - RW'(1);
            col_r   <= CLW'(cnt_r);
            state_r <= S_POST;
          end else begin
            cnt_r   <= cnt_r + CW'(1);
            state_r <= S_BS_RD;
          end
        end
        S_POST: begin
          col_r <= col_wrap ? '0 : col_r;
          if (row_w >= RW'(ROWS)) begin
            row_r    <= row_w - RW'(1);
            cnt_r    <= CW'(COLUMNS);
            pend_v_r <= 1'b0;
            state_r  <= S_SC_COPY;
          end else begin
            row_r   <= row_w;
            state_r <= S_FINISH;
          end
        end
        S_SC_COPY: begin
          if (cnt_r < CW'(NCELLS)) begin
            pend_v_r    <= 1'b1;
            pend_addr_r <= AW'(cnt_r - CW'(COLUMNS));
            cnt_r       <= cnt_r + CW'(1);
          end else begin
            pend_v_r <= 1'b0;
            if (!pend_v_r) begin
              cnt_r   <= CW'(NCELLS - COLUMNS);
              state_r <= S_SC_BLANK;
            end
          end
        end
        S_SC_BLANK: begin
          if (cnt_r == CW'(NCELLS - 1)) begin
            state_r <= S_FINISH;
          end
          cnt_r <= cnt_r + CW'(1);
        end
        S_FINISH: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`include "text_terminal_char_writer_unit_macros.svh"

  `TTCW_ASSERT(a_cursor_in_range, (state_r != S_IDLE) || ((row_r < RW'(ROWS)) && (col_r < CLW'(COLUMNS))))
  `TTCW_ASSERT(a_no_write_when_idle, (state_r != S_IDLE) || !wr_en)
  `TTCW_ASSERT_NEXT(a_accept_starts_work, in_tvalid && in_tready, state_r == S_EXEC)
  `TTCW_ASSERT(a_copy_trails_read, !((state_r == S_SC_COPY) && wr_en && rd_en) || (wr_addr < rd_addr))
  `TTCW_ASSERT_NEXT(a_finish_loads_output, out_load, out_tvalid_r && (state_r == S_IDLE))

endmodule
